>>> sv/markup_comment_doctype_stripper_macros.svh
// Assertion helpers for the markup stripper.
// Each macro expects clk and rst_n in scope.
`ifndef MARKUP_COMMENT_DOCTYPE_STRIPPER_MACROS_SVH
`define MARKUP_COMMENT_DOCTYPE_STRIPPER_MACROS_SVH

// Same-cycle implication.
`define MCDS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCDS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mcds_pkg.sv
// ----------------------------------------------------------------------------
// mcds_pkg
// Types, character codes and opener patterns for the markup stripper.
// ----------------------------------------------------------------------------
package mcds_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       doc_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] kept_byte;
    logic       byte_valid;
    logic       run_last;
    logic       doc_end;
  } out_item_t;

  typedef enum logic [4:0] {
    MODE_NORMAL        = 5'b00001,
    MODE_COMMENT       = 5'b00010,
    MODE_DOCTYPE       = 5'b00100,
    MODE_SUBSET        = 5'b01000,
    MODE_AFTER_SUBSET  = 5'b10000
  } scan_mode_t;

  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
  localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
  localparam logic [7:0] CH_UPPERD = 8'h44;  // 'D'
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'

  localparam logic [3:0] COMMENT_LEN = 4'd4;
  localparam logic [3:0] DOCTYPE_LEN = 4'd9;

  localparam logic [7:0] COMMENT_PAT [4] = '{8'h3C, 8'h21, 8'h2D, 8'h2D};
  localparam logic [7:0] DOCTYPE_PAT [9] = '{8'h3C, 8'h21, 8'h44, 8'h4F, 8'h43,
                                             8'h54, 8'h59, 8'h50, 8'h45};

  // Byte k of the opener pattern that a held prefix follows.
  function automatic logic [7:0] held_char(input logic is_doctype, input logic [3:0] k);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_doctype) begin
      if (k < DOCTYPE_LEN) begin
        ch = DOCTYPE_PAT[k];
      end
    end else begin
      ch = COMMENT_PAT[k[1:0]];
    end
    return ch;
  endfunction

endpackage

>>> sv/markup_comment_doctype_stripper.sv
// ----------------------------------------------------------------------------
// markup_comment_doctype_stripper
// Removes comment and DOCTYPE spans from a byte stream, one document at a time.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload     | handshake
//   in_     | input     | in_item_t   | in_valid / in_ready
//   out_    | output    | out_item_t  | out_valid / out_ready
//
// Each input byte sits in an input register while its results are produced;
// the opener matcher and result selection sit between that register and the
// output register. Each item gives one result per cycle while the output is
// free, at most nine for an item that releases a held prefix; an item with
// no result leaves the input register without using the output.
// rst_n clears all scan state and both valid flags; out_ready low holds the
// output register and stalls the input behind an item with results to give.

module markup_comment_doctype_stripper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcds_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcds_pkg::out_item_t  out_data
);
  import mcds_pkg::*;

  `include "markup_comment_doctype_stripper_macros.svh"

  logic       item_valid_r;
  in_item_t   item_r;
  logic [3:0] idx_r;

  scan_mode_t mode_r, mode_nxt;
  logic [3:0] pm_r, pm_nxt;
  logic       dt_r, dt_nxt;
  logic [1:0] dash_r, dash_nxt;

  logic       out_valid_r;
  out_item_t  out_r, out_nxt;

  logic [7:0] b;
  logic       last;
  logic       fresh;
  logic       tail_emit;
  logic       bare;
  logic [3:0] flush_cnt;
  logic       flush_dt;
  logic [3:0] opener_len;
  logic [3:0] n_items;
  logic       out_free;
  logic       emit;
  logic       final_res;
  logic       consume;

  assign b    = item_r.text_byte;
  assign last = item_r.doc_last;
  assign opener_len = dt_r ? DOCTYPE_LEN : COMMENT_LEN;

  // Next scan state and the shape of this item's result list.
  always_comb begin
    mode_nxt  = mode_r;
    pm_nxt    = pm_r;
    dt_nxt    = dt_r;
    dash_nxt  = dash_r;
    flush_cnt = 4'd0;
    flush_dt  = dt_r;
    fresh     = 1'b0;
    unique case (mode_r)
      MODE_COMMENT: begin
        if (b == CH_DASH) begin
          if (dash_r != 2'd2) begin
            dash_nxt = dash_r + 2'd1;
          end
        end else begin
          if (b == CH_GT && dash_r == 2'd2) begin
            mode_nxt = MODE_NORMAL;
          end
          dash_nxt = 2'd0;
        end
      end
      MODE_DOCTYPE: begin
        if (b == CH_GT) begin
          mode_nxt = MODE_NORMAL;
        end else if (b == CH_LBRACK) begin
          mode_nxt = MODE_SUBSET;
        end
      end
      MODE_SUBSET: begin
        if (b == CH_RBRACK) begin
          mode_nxt = MODE_AFTER_SUBSET;
        end
      end
      MODE_AFTER_SUBSET: begin
        if (b == CH_GT) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        priority if (pm_r == 4'd0) begin
          fresh = 1'b1;
        end else if (pm_r == 4'd1) begin
          if (b == CH_BANG) begin
            pm_nxt = 4'd2;
          end else begin
            fresh = 1'b1;
          end
        end else if (pm_r == 4'd2) begin
          priority if (b == CH_DASH) begin
            pm_nxt = 4'd3;
            dt_nxt = 1'b0;
          end else if (b == CH_UPPERD) begin
            pm_nxt = 4'd3;
            dt_nxt = 1'b1;
          end else begin
            fresh = 1'b1;
          end
        end else begin
          if (pm_r < opener_len && b == held_char(dt_r, pm_r)) begin
            if (pm_r + 4'd1 == opener_len) begin
              mode_nxt = dt_r ? MODE_DOCTYPE : MODE_COMMENT;
              dash_nxt = 2'd0;
              pm_nxt   = 4'd0;
              dt_nxt   = 1'b0;
            end else begin
              pm_nxt = pm_r + 4'd1;
            end
          end else begin
            fresh = 1'b1;
          end
        end
        // A mismatch releases the held prefix ahead of the current byte.
        if (fresh) begin
          flush_cnt = pm_r;
          flush_dt  = dt_r;
          pm_nxt    = (b == CH_LT) ? 4'd1 : 4'd0;
          dt_nxt    = 1'b0;
        end
      end
    endcase
    // A prefix that merely grew is released whole at document end.
    if (last && !fresh && mode_nxt == MODE_NORMAL) begin
      flush_cnt = pm_nxt;
      flush_dt  = dt_nxt;
    end
  end

  // A fresh '<' is held, unless the document ends on it.
  assign tail_emit = fresh && (b != CH_LT || last);
  assign bare      = last && flush_cnt == 4'd0 && !tail_emit;
  assign n_items   = flush_cnt + {3'd0, tail_emit} + {3'd0, bare};

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = item_valid_r && n_items != 4'd0 && out_free;
  assign final_res = idx_r == n_items - 4'd1;
  assign consume   = item_valid_r && (n_items == 4'd0 || (emit && final_res));
  assign in_ready  = !item_valid_r || consume;

  always_comb begin
    out_nxt = '0;
    priority if (idx_r < flush_cnt) begin
      out_nxt.kept_byte  = held_char(flush_dt, idx_r);
      out_nxt.byte_valid = 1'b1;
    end else if (tail_emit) begin
      out_nxt.kept_byte  = b;
      out_nxt.byte_valid = 1'b1;
    end else begin
      // Bare end marker.
      out_nxt.byte_valid = 1'b0;
    end
    out_nxt.run_last = final_res;
    out_nxt.doc_end  = final_res && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      idx_r        <= 4'd0;
      mode_r       <= MODE_NORMAL;
      pm_r         <= 4'd0;
      dt_r         <= 1'b0;
      dash_r       <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid_r <= 1'b1;
      end else if (consume) begin
        item_valid_r <= 1'b0;
      end
      if (consume) begin
        idx_r <= 4'd0;
        if (last) begin
          mode_r <= MODE_NORMAL;
          pm_r   <= 4'd0;
          dt_r   <= 1'b0;
          dash_r <= 2'd0;
        end else begin
          mode_r <= mode_nxt;
          pm_r   <= pm_nxt;
          dt_r   <= dt_nxt;
          dash_r <= dash_nxt;
        end
      end else if (emit) begin
        idx_r <= idx_r + 4'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MCDS_ASSERT_NOW(a_idx_in_range, item_valid_r && n_items != 4'd0, idx_r < n_items,
                   "result index ran past the item's result count")
  `MCDS_ASSERT_NOW(a_prefix_only_normal, pm_r != 4'd0, mode_r == MODE_NORMAL,
                   "opener prefix held outside normal content")
  `MCDS_ASSERT_NOW(a_dash_saturates, 1'b1, dash_r != 2'd3,
                   "dash run exceeded its saturation value")
  `MCDS_ASSERT_NEXT(a_doc_end_resets, consume && last,
                    mode_r == MODE_NORMAL && pm_r == 4'd0 && dash_r == 2'd0,
                    "scan state not cleared after document end")
  `MCDS_ASSERT_NOW(a_bare_marker_ends_doc, out_valid_r && !out_r.byte_valid,
                   out_r.run_last && out_r.doc_end,
                   "bare end marker without run and document end flags")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the markup comment and DOCTYPE stripper. A short
// table of directed bytes is followed by random documents built from random
// bytes, comment and DOCTYPE spans and cut-short openers. Every byte accepted
// on the input is run through a behavioral stripper here, and each output
// transfer is checked against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
  import mcds_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 425;
  localparam int LONG_STALL   = 300;
  localparam int N_DIRECTED   = 23;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  // Rows with typed set carry an expectation that is plain from the input alone.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    {8'h00,     1'b0, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0}},
    {8'hFF,     1'b1, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b1}},
    {CH_LT,     1'b0, 1'b0, 11'd0},
    {CH_BANG,   1'b0, 1'b0, 11'd0},
    {CH_DASH,   1'b0, 1'b0, 11'd0},
    {CH_DASH,   1'b0, 1'b0, 11'd0},
    {CH_GT,     1'b0, 1'b0, 11'd0},
    {CH_DASH,   1'b0, 1'b0, 11'd0},
    {CH_GT,     1'b0, 1'b0, 11'd0},
    {CH_DASH,   1'b0, 1'b0, 11'd0},
    {CH_DASH,   1'b0, 1'b0, 11'd0},
    {CH_GT,     1'b0, 1'b0, 11'd0},
    {8'h41,     1'b1, 1'b1, {8'h41, 1'b1, 1'b1, 1'b1}},
    {CH_LT,     1'b0, 1'b0, 11'd0},
    {CH_BANG,   1'b0, 1'b0, 11'd0},
    {CH_UPPERD, 1'b0, 1'b0, 11'd0},
    {CH_LT,     1'b0, 1'b0, 11'd0},
    {CH_BANG,   1'b1, 1'b0, 11'd0},
    {CH_LT,     1'b0, 1'b0, 11'd0},
    {CH_BANG,   1'b0, 1'b0, 11'd0},
    {CH_DASH,   1'b0, 1'b0, 11'd0},
    {CH_DASH,   1'b0, 1'b0, 11'd0},
    {8'h00,     1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}}
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  markup_comment_doctype_stripper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("** markup_comment_doctype_stripper: FAILED **");
    $finish;
  end

  // Behavioral copy of the stripper state.
  scan_mode_t strip_mode   = MODE_NORMAL;
  logic [3:0] held_len     = '0;
  logic       held_doctype = 1'b0;
  logic [1:0] dash_len     = '0;

  out_item_t  step_kept [$];
  out_item_t  kept_results_q [$];
  out_item_t  want_item;
  int         fail_count    = 0;
  int         result_count  = 0;
  int         idle_phase    = 0;
  int         stall_left    = 0;
  logic       long_stall_done = 1'b0;
  logic [7:0] doc_bytes [$];

  function automatic logic [7:0] opener_char(input logic is_dt, input logic [3:0] k);
    return is_dt ? DOCTYPE_PAT[k] : COMMENT_PAT[k[1:0]];
  endfunction

  function automatic void add_doc_byte(input logic [7:0] b);
    doc_bytes = {doc_bytes, b};
  endfunction

  function automatic void keep_byte(input logic [7:0] b, input logic valid);
    out_item_t r;
    r.kept_byte  = b;
    r.byte_valid = valid;
    r.run_last   = 1'b0;
    r.doc_end    = 1'b0;
    step_kept = {step_kept, r};
  endfunction

  function automatic void release_held();
    for (int k = 0; k < held_len; k++) keep_byte(opener_char(held_doctype, k[3:0]), 1'b1);
    held_len     = '0;
    held_doctype = 1'b0;
  endfunction

  function automatic void fresh_content(input logic [7:0] b);
    if (b == CH_LT) begin
      held_len     = 4'd1;
      held_doctype = 1'b0;
    end else begin
      keep_byte(b, 1'b1);
    end
  endfunction

  function automatic void content_byte(input logic [7:0] b);
    logic       matched;
    logic [3:0] open_len;
    logic [3:0] m;
    matched  = 1'b0;
    m        = held_len;
    open_len = held_doctype ? DOCTYPE_LEN : COMMENT_LEN;
    if (m == 0) begin
      fresh_content(b);
      matched = 1'b1;
    end else if (m == 1) begin
      if (b == CH_BANG) begin
        held_len = 4'd2;
        matched  = 1'b1;
      end
    end else if (m == 2) begin
      if (b == CH_DASH || b == CH_UPPERD) begin
        held_len     = 4'd3;
        held_doctype = (b == CH_UPPERD);
        matched      = 1'b1;
      end
    end else if (m < open_len && b == opener_char(held_doctype, m)) begin
      matched = 1'b1;
      m = m + 4'd1;
      if (m == open_len) begin
        strip_mode   = held_doctype ? MODE_DOCTYPE : MODE_COMMENT;
        dash_len     = '0;
        held_len     = '0;
        held_doctype = 1'b0;
      end else begin
        held_len = m;
      end
    end
    if (!matched) begin
      release_held();
      fresh_content(b);
    end
  endfunction

  // Works out the results of one accepted byte into step_kept.
  function automatic void strip_step(input in_item_t it);
    step_kept.delete();
    case (strip_mode)
      MODE_COMMENT: begin
        if (it.text_byte == CH_DASH) begin
          if (dash_len < 2) dash_len = dash_len + 2'd1;
        end else begin
          if (it.text_byte == CH_GT && dash_len == 2) strip_mode = MODE_NORMAL;
          dash_len = '0;
        end
      end
      MODE_DOCTYPE: begin
        if (it.text_byte == CH_GT) strip_mode = MODE_NORMAL;
        else if (it.text_byte == CH_LBRACK) strip_mode = MODE_SUBSET;
      end
      MODE_SUBSET: begin
        if (it.text_byte == CH_RBRACK) strip_mode = MODE_AFTER_SUBSET;
      end
      MODE_AFTER_SUBSET: begin
        if (it.text_byte == CH_GT) strip_mode = MODE_NORMAL;
      end
      default: begin
        strip_mode = MODE_NORMAL;
        content_byte(it.text_byte);
      end
    endcase
    if (it.doc_last) begin
      if (strip_mode == MODE_NORMAL) release_held();
      if (step_kept.size() == 0) keep_byte(8'h00, 1'b0);
      step_kept[step_kept.size() - 1].doc_end = 1'b1;
      strip_mode   = MODE_NORMAL;
      held_len     = '0;
      held_doctype = 1'b0;
      dash_len     = '0;
    end
    if (step_kept.size() > 0) begin
      step_kept[step_kept.size() - 1].run_last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_count, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (kept_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, byte %02h", out_data.kept_byte));
      end else begin
        want_item = kept_results_q.pop_front();
        if (out_data.kept_byte !== want_item.kept_byte)
          report_mismatch($sformatf("kept_byte %02h, expected %02h",
                                    out_data.kept_byte, want_item.kept_byte));
        if (out_data.byte_valid !== want_item.byte_valid)
          report_mismatch($sformatf("byte_valid %b, expected %b",
                                    out_data.byte_valid, want_item.byte_valid));
        if (out_data.run_last !== want_item.run_last)
          report_mismatch($sformatf("run_last %b, expected %b",
                                    out_data.run_last, want_item.run_last));
        if (out_data.doc_end !== want_item.doc_end)
          report_mismatch($sformatf("doc_end %b, expected %b",
                                    out_data.doc_end, want_item.doc_end));
      end
      result_count++;
    end
  end

  // Output side: random stalls by phase, plus one long hold-off that backs up the input.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_phase == 2 && !long_stall_done) begin
      long_stall_done <= 1'b1;
      stall_left      <= LONG_STALL;
      out_ready       <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= (idle_phase == 0 ? 46 : idle_phase == 1 ? 6 : 0));
    end
  end

  // Offers one byte, waits for its transfer and records what it should produce.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input out_item_t want);
    in_item_t it;
    it.text_byte = b;
    it.doc_last  = last;
    while ($urandom_range(0, 99) < (idle_phase == 0 ? 6 : idle_phase == 1 ? 46 : 0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    strip_step(it);
    if (typed) kept_results_q = {kept_results_q, want};
    else kept_results_q = {kept_results_q, step_kept};
    @(negedge clk);
  endtask

  function automatic logic [7:0] markup_char();
    case ($urandom_range(0, 7))
      0: return CH_LT;
      1: return CH_GT;
      2: return CH_BANG;
      3: return CH_DASH;
      4: return CH_UPPERD;
      5: return CH_LBRACK;
      6: return CH_RBRACK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int         sent;
    int         target;
    int         n;
    logic [7:0] junk;
    sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].text, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

    while (sent < RANDOM_ITEMS) begin
      idle_phase = (sent < RANDOM_ITEMS / 3) ? 0 : (sent < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
      doc_bytes.delete();
      target = $urandom_range(1, 30);
      while (doc_bytes.size() < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2: add_doc_byte(8'($urandom_range(0, 255)));
          3: add_doc_byte(markup_char());
          4, 5: begin
            foreach (COMMENT_PAT[k]) add_doc_byte(COMMENT_PAT[k]);
            n = $urandom_range(0, 6);
            repeat (n) add_doc_byte(markup_char());
            if ($urandom_range(0, 4) != 0) begin
              add_doc_byte(CH_DASH);
              add_doc_byte(CH_DASH);
              add_doc_byte(CH_GT);
            end
          end
          6, 7: begin
            foreach (DOCTYPE_PAT[k]) add_doc_byte(DOCTYPE_PAT[k]);
            n = $urandom_range(0, 4);
            repeat (n) add_doc_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
              add_doc_byte(CH_LBRACK);
              n = $urandom_range(0, 4);
              repeat (n) add_doc_byte(markup_char());
              add_doc_byte(CH_RBRACK);
              n = $urandom_range(0, 2);
              repeat (n) add_doc_byte(markup_char());
            end
            add_doc_byte(CH_GT);
          end
          8: begin
            // Opener cut short, so the held prefix has to be released.
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
              add_doc_byte((n < 4 && $urandom_range(0, 1)) ? COMMENT_PAT[k] : DOCTYPE_PAT[k]);
          end
          default: begin
            add_doc_byte(CH_LT);
            add_doc_byte(CH_BANG);
          end
        endcase
      end
      // Now and then the document stops mid-span or mid-opener.
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, doc_bytes.size());
        while (doc_bytes.size() > n) junk = doc_bytes.pop_back();
      end
      foreach (doc_bytes[i]) begin
        send_byte(doc_bytes[i], i == doc_bytes.size() - 1, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (kept_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** markup_comment_doctype_stripper: PASSED **");
    end else begin
      $display("** markup_comment_doctype_stripper: FAILED **");
    end
    $finish;
  end

endmodule
